>>> sv/ecq_pkg.sv
// Shared types and constants for the exhaustion confirmation qualifier.
`timescale 1ns / 1ps

package ecq_pkg;

	// Fixed field widths
	localparam int unsigned GEN_W    = 32;
	localparam int unsigned FCNT_W   = 16;
	localparam int unsigned CODE_W   = 2;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned MINOBS_W = 16;
	localparam int unsigned MSTAB_W  = 32;
	localparam int unsigned TOUT_W   = 32;
	localparam int unsigned MASK_W   = 3;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned REGSEL_W = 2;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	// Planner status codes
	localparam logic [CODE_W-1:0] ST_OTHER          = 2'd0;
	localparam logic [CODE_W-1:0] ST_NO_FRONTIERS   = 2'd1;
	localparam logic [CODE_W-1:0] ST_NO_REACHABLE   = 2'd2;
	localparam logic [CODE_W-1:0] ST_NO_SELECTABLE  = 2'd3;

	// Register indexes (byte address / 4)
	localparam logic [REGSEL_W-1:0] REG_MIN_OBS     = 2'd0;
	localparam logic [REGSEL_W-1:0] REG_MIN_STABLE  = 2'd1;
	localparam logic [REGSEL_W-1:0] REG_TIMEOUT     = 2'd2;
	localparam logic [REGSEL_W-1:0] REG_ALLOW_MASK  = 2'd3;

	// Register reset values
	localparam logic [MINOBS_W-1:0] MIN_OBS_RST    = 16'd3;
	localparam logic [MSTAB_W-1:0]  MIN_STABLE_RST = 32'd0;
	localparam logic [TOUT_W-1:0]   TIMEOUT_RST    = 32'd1000;
	localparam logic [MASK_W-1:0]   ALLOW_MASK_RST = 3'b111;

	typedef enum logic [1:0] {
		KIND_NONE          = 2'd0,
		KIND_NO_FRONTIERS  = 2'd1,
		KIND_NO_REACHABLE  = 2'd2,
		KIND_NO_SELECTABLE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		RSN_INIT          = 4'd0,
		RSN_NO_PLAN       = 4'd1,
		RSN_RESTARTED     = 4'd2,
		RSN_NOT_EXHAUSTED = 4'd3,
		RSN_INADMISSIBLE  = 4'd4,
		RSN_STALE         = 4'd5,
		RSN_OBSERVED      = 4'd6,
		RSN_CONFIRMED     = 4'd7,
		RSN_CLEARED       = 4'd8
	} reason_t;

endpackage

>>> sv/exhaustion_confirm_qualifier.sv
// Exhaustion confirmation qualifier: classifies plan reports and confirms exhaustion.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall  | mode, now_ms, received_at_ms, plan_seq, ...
//  out     | source    | out_valid/out_stall| status_seen, ..., held_status_code
//  cfg     | APB slave | psel/penable/pready| four registers at byte address 4*i
//
//  One transaction per cycle sustained while out_stall is low. An accepted transaction
//  is held in the input register; when it advances, its result is loaded into the
//  state/result registers and out_valid is raised.
//  The state update is one pass of compares, two subtractions and a counter increment
//  feeding back on itself.
//  arst_n clears all state and restores the register defaults; no clearing pass.
//  A stalled result holds the state, and the input register stalls behind it.

module exhaustion_confirm_qualifier #(
	parameter int unsigned TIME_WIDTH  = 32,
	parameter int unsigned SEQ_WIDTH   = 32,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [ecq_pkg::MODE_W-1:0]             mode,
	input  logic [TIME_WIDTH-1:0]                  now_ms,
	input  logic [TIME_WIDTH-1:0]                  received_at_ms,
	input  logic [SEQ_WIDTH-1:0]                   plan_seq,
	input  logic [ecq_pkg::GEN_W-1:0]              map_gen,
	input  logic [ecq_pkg::GEN_W-1:0]              planned_gen,
	input  logic [ecq_pkg::FCNT_W-1:0]             detected_count,
	input  logic [ecq_pkg::FCNT_W-1:0]             reachable_count,
	input  logic [ecq_pkg::CODE_W-1:0]             status_code,
	input  logic                                   explore_on,
	input  logic                                   goal_busy,
	input  logic                                   handover_busy,

	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   status_seen,
	output logic                                   report_recent,
	output logic                                   candidate,
	output logic                                   confirmed,
	output logic [1:0]                             depletion_kind,
	output logic [COUNT_WIDTH-1:0]                 observation_count,
	output logic [TIME_WIDTH-1:0]                  stable_ms,
	output logic [SEQ_WIDTH-1:0]                   last_plan_seq,
	output logic [3:0]                             reason_code,
	output logic [ecq_pkg::GEN_W-1:0]              held_map_gen,
	output logic [ecq_pkg::GEN_W-1:0]              held_planned_gen,
	output logic [ecq_pkg::CODE_W-1:0]             held_status_code,

	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [ecq_pkg::ADDR_W-1:0]             paddr,
	input  logic [ecq_pkg::DATA_W-1:0]             pwdata,
	output logic [ecq_pkg::DATA_W-1:0]             prdata,
	output logic                                   pready
);

	// Compare widths wide enough for a value and its register (32-bit time, 16-bit count)
	localparam int unsigned TCMP_W = (TIME_WIDTH > ecq_pkg::MSTAB_W) ?
		TIME_WIDTH : ecq_pkg::MSTAB_W;
	localparam int unsigned OCMP_W = (COUNT_WIDTH > ecq_pkg::MINOBS_W) ?
		COUNT_WIDTH : ecq_pkg::MINOBS_W;

	typedef struct packed {
		logic                         active;
		logic                         confirmed;
		ecq_pkg::kind_t               kind;
		logic [COUNT_WIDTH-1:0]       obs;
		logic [TIME_WIDTH-1:0]        stable;
		logic [TIME_WIDTH-1:0]        start;
		logic [ecq_pkg::GEN_W-1:0]    map_gen;
		logic [ecq_pkg::GEN_W-1:0]    planned_gen;
	} cand_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [ecq_pkg::MINOBS_W-1:0] min_obs_q;
	logic [ecq_pkg::MSTAB_W-1:0]  min_stable_q;
	logic [ecq_pkg::TOUT_W-1:0]   timeout_q;
	logic [ecq_pkg::MASK_W-1:0]   allow_mask_q;
	logic                         cfg_wr;
	logic [ecq_pkg::REGSEL_W-1:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ecq_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_obs_q    <= ecq_pkg::MIN_OBS_RST;
			min_stable_q <= ecq_pkg::MIN_STABLE_RST;
			timeout_q    <= ecq_pkg::TIMEOUT_RST;
			allow_mask_q <= ecq_pkg::ALLOW_MASK_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				ecq_pkg::REG_MIN_OBS:    min_obs_q    <= pwdata[ecq_pkg::MINOBS_W-1:0];
				ecq_pkg::REG_MIN_STABLE: min_stable_q <= pwdata[ecq_pkg::MSTAB_W-1:0];
				ecq_pkg::REG_TIMEOUT:    timeout_q    <= pwdata[ecq_pkg::TOUT_W-1:0];
				ecq_pkg::REG_ALLOW_MASK: allow_mask_q <= pwdata[ecq_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_sel)
			ecq_pkg::REG_MIN_OBS:    prdata = ecq_pkg::DATA_W'(min_obs_q);
			ecq_pkg::REG_MIN_STABLE: prdata = ecq_pkg::DATA_W'(min_stable_q);
			ecq_pkg::REG_TIMEOUT:    prdata = ecq_pkg::DATA_W'(timeout_q);
			ecq_pkg::REG_ALLOW_MASK: prdata = ecq_pkg::DATA_W'(allow_mask_q);
			default:                 prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic                          valid_s1;
	logic                          advance;
	logic                          in_take;
	logic [ecq_pkg::MODE_W-1:0]    mode_s1;
	logic [TIME_WIDTH-1:0]         now_s1;
	logic [TIME_WIDTH-1:0]         rx_s1;
	logic [SEQ_WIDTH-1:0]          seq_s1;
	logic [ecq_pkg::GEN_W-1:0]     mg_s1;
	logic [ecq_pkg::GEN_W-1:0]     pg_s1;
	logic [ecq_pkg::FCNT_W-1:0]    det_s1;
	logic [ecq_pkg::FCNT_W-1:0]    reach_s1;
	logic [ecq_pkg::CODE_W-1:0]    code_s1;
	logic                          run_s1;
	logic                          goal_s1;
	logic                          hand_s1;
	logic                          out_valid_q;

	// The stage moves on whenever the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload of an accepted transaction
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1  <= mode;
			now_s1   <= now_ms;
			rx_s1    <= received_at_ms;
			seq_s1   <= plan_seq;
			mg_s1    <= map_gen;
			pg_s1    <= planned_gen;
			det_s1   <= detected_count;
			reach_s1 <= reachable_count;
			code_s1  <= status_code;
			run_s1   <= explore_on;
			goal_s1  <= goal_busy;
			hand_s1  <= handover_busy;
		end
	end

	// ---------------------------------------------------------------
	// State, which is also the result register
	// ---------------------------------------------------------------
	logic                          seen_q, fresh_q;
	cand_t                         cand_q;
	logic [TIME_WIDTH-1:0]         last_rx_q;
	logic [SEQ_WIDTH-1:0]          seq_q;
	logic [ecq_pkg::GEN_W-1:0]     echo_mg_q, echo_pg_q;
	logic [ecq_pkg::CODE_W-1:0]    echo_code_q;
	ecq_pkg::reason_t              reason_q;

	logic                          seen_n, fresh_n;
	cand_t                         cand_n;
	logic [TIME_WIDTH-1:0]         last_rx_n;
	logic [SEQ_WIDTH-1:0]          seq_n;
	logic [ecq_pkg::GEN_W-1:0]     echo_mg_n, echo_pg_n;
	logic [ecq_pkg::CODE_W-1:0]    echo_code_n;
	ecq_pkg::reason_t              reason_n;

	// Report decode
	logic                          is_report;
	logic [TIME_WIDTH-1:0]         rx_eff;
	logic [TIME_WIDTH-1:0]         age;
	logic                          age_ok;
	ecq_pkg::kind_t                kind;
	logic                          admit;
	logic [TIME_WIDTH-1:0]         elapsed;
	logic                          elapsed_ok;

	assign is_report = (mode_s1 == ecq_pkg::MODE_REPORT);
	assign rx_eff    = is_report ? rx_s1 : last_rx_q;
	assign age       = (now_s1 >= rx_eff) ? (now_s1 - rx_eff) : '0;
	assign age_ok    = TCMP_W'(age) <= TCMP_W'(timeout_q);

	// Classify the report into an exhaustion kind
	always_comb begin
		priority if (code_s1 == ecq_pkg::ST_NO_FRONTIERS && det_s1 == '0 && reach_s1 == '0)
			kind = ecq_pkg::KIND_NO_FRONTIERS;
		else if (code_s1 == ecq_pkg::ST_NO_REACHABLE && det_s1 != '0 && reach_s1 == '0)
			kind = ecq_pkg::KIND_NO_REACHABLE;
		else if (code_s1 == ecq_pkg::ST_NO_SELECTABLE && det_s1 != '0)
			kind = ecq_pkg::KIND_NO_SELECTABLE;
		else
			kind = ecq_pkg::KIND_NONE;
	end

	assign admit = ((kind == ecq_pkg::KIND_NO_FRONTIERS  && allow_mask_q[0]) ||
	                (kind == ecq_pkg::KIND_NO_REACHABLE  && allow_mask_q[1]) ||
	                (kind == ecq_pkg::KIND_NO_SELECTABLE && allow_mask_q[2])) &&
	               run_s1 && !goal_s1 && !hand_s1;

	// Next-state logic for one transaction
	always_comb begin
		seen_n      = seen_q;
		fresh_n     = fresh_q;
		cand_n      = cand_q;
		last_rx_n   = last_rx_q;
		seq_n       = seq_q;
		echo_mg_n   = echo_mg_q;
		echo_pg_n   = echo_pg_q;
		echo_code_n = echo_code_q;
		reason_n    = reason_q;
		elapsed     = '0;
		elapsed_ok  = 1'b0;

		unique case (mode_s1)
			ecq_pkg::MODE_CLEAR: begin
				seen_n      = 1'b0;
				fresh_n     = 1'b0;
				cand_n      = '0;
				last_rx_n   = '0;
				seq_n       = '0;
				echo_mg_n   = '0;
				echo_pg_n   = '0;
				echo_code_n = '0;
				reason_n    = ecq_pkg::RSN_CLEARED;
			end
			ecq_pkg::MODE_REPORT: begin
				seen_n      = 1'b1;
				last_rx_n   = rx_s1;
				fresh_n     = age_ok;
				echo_mg_n   = mg_s1;
				echo_pg_n   = pg_s1;
				echo_code_n = code_s1;
				if (seq_s1 == '0) begin
					// No plan: drop an unconfirmed candidate
					if (!cand_q.confirmed) begin
						cand_n   = '0;
						reason_n = ecq_pkg::RSN_NO_PLAN;
					end
				end else if (seq_s1 == seq_q) begin
					// Repeated report: freshness check only
					if (!age_ok && !cand_q.confirmed) begin
						cand_n   = '0;
						reason_n = ecq_pkg::RSN_STALE;
					end
				end else begin
					seq_n = seq_s1;
					// A restarted planner drops the candidate before the report is taken
					if (seq_s1 < seq_q)
						cand_n = '0;
					if (!admit) begin
						cand_n   = '0;
						reason_n = (kind == ecq_pkg::KIND_NONE) ?
							ecq_pkg::RSN_NOT_EXHAUSTED : ecq_pkg::RSN_INADMISSIBLE;
					end else begin
						if (cand_n.active && cand_n.kind == kind &&
						    cand_n.map_gen == mg_s1 && cand_n.planned_gen == pg_s1) begin
							// Same candidate: count and measure its age
							if (cand_n.obs != '1)
								cand_n.obs = cand_n.obs + COUNT_WIDTH'(1);
							if (now_s1 >= cand_n.start) begin
								elapsed    = now_s1 - cand_n.start;
								elapsed_ok = TCMP_W'(elapsed) >= TCMP_W'(min_stable_q);
							end
							cand_n.stable = elapsed;
						end else begin
							// New candidate
							cand_n.active      = 1'b1;
							cand_n.confirmed   = 1'b0;
							cand_n.kind        = kind;
							cand_n.obs         = COUNT_WIDTH'(1);
							cand_n.stable      = '0;
							cand_n.start       = now_s1;
							cand_n.map_gen     = mg_s1;
							cand_n.planned_gen = pg_s1;
							elapsed_ok         = (min_stable_q == '0);
						end
						reason_n = ecq_pkg::RSN_OBSERVED;
						if (OCMP_W'(cand_n.obs) >= OCMP_W'(min_obs_q) && elapsed_ok) begin
							cand_n.confirmed = 1'b1;
							reason_n         = ecq_pkg::RSN_CONFIRMED;
						end
					end
				end
			end
			default: begin
				// Tick: refresh freshness, drop a stale unconfirmed candidate
				fresh_n = seen_q && age_ok;
				if (!fresh_n && !cand_q.confirmed) begin
					cand_n   = '0;
					reason_n = ecq_pkg::RSN_STALE;
				end
			end
		endcase
	end

	// Commit the state when the transaction moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			fresh_q     <= 1'b0;
			cand_q      <= '0;
			last_rx_q   <= '0;
			seq_q       <= '0;
			echo_mg_q   <= '0;
			echo_pg_q   <= '0;
			echo_code_q <= '0;
			reason_q    <= ecq_pkg::RSN_INIT;
		end else if (advance) begin
			seen_q      <= seen_n;
			fresh_q     <= fresh_n;
			cand_q      <= cand_n;
			last_rx_q   <= last_rx_n;
			seq_q       <= seq_n;
			echo_mg_q   <= echo_mg_n;
			echo_pg_q   <= echo_pg_n;
			echo_code_q <= echo_code_n;
			reason_q    <= reason_n;
		end
	end

	// Hold the result valid until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign status_seen       = seen_q;
	assign report_recent     = fresh_q;
	assign candidate         = cand_q.active;
	assign confirmed         = cand_q.confirmed;
	assign depletion_kind    = cand_q.kind;
	assign observation_count = cand_q.obs;
	assign stable_ms         = cand_q.stable;
	assign last_plan_seq     = seq_q;
	assign reason_code       = reason_q;
	assign held_map_gen      = echo_mg_q;
	assign held_planned_gen  = echo_pg_q;
	assign held_status_code  = echo_code_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_confirm_needs_cand: assert property (@(posedge clk) disable iff (!arst_n)
		cand_q.confirmed |-> cand_q.active)
		else $error("confirmed without a candidate");

	a_cand_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cand_q.active |-> (cand_q.kind != ecq_pkg::KIND_NONE && cand_q.obs != '0))
		else $error("candidate with no kind or no observation");

	a_fresh_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> seen_q)
		else $error("fresh status without any report");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_s1 == ecq_pkg::MODE_CLEAR) |=>
		(reason_q == ecq_pkg::RSN_CLEARED && !seen_q && !cand_q.active))
		else $error("clear did not reset the state");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(cand_q) && $stable(reason_q)))
		else $error("state changed under a stalled result");

endmodule

>>> test/tb_exhaustion_confirm_qualifier.sv
// Self-checking testbench for the exhaustion confirmation qualifier.
`timescale 1ns / 1ps

module tb_exhaustion_confirm_qualifier;

	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned PHASE_ITEMS     = 160;
	localparam int unsigned LONG_ITEMS      = 40;
	localparam int unsigned PRINT_LIMIT     = 100;
	localparam logic [ecq_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [ecq_pkg::MODE_W-1:0]  mode;
		logic [31:0]                 now_ms;
		logic [31:0]                 received_at_ms;
		logic [31:0]                 plan_seq;
		logic [ecq_pkg::GEN_W-1:0]   map_gen;
		logic [ecq_pkg::GEN_W-1:0]   planned_gen;
		logic [ecq_pkg::FCNT_W-1:0]  detected_count;
		logic [ecq_pkg::FCNT_W-1:0]  reachable_count;
		logic [ecq_pkg::CODE_W-1:0]  status_code;
		logic                        explore_on;
		logic                        goal_busy;
		logic                        handover_busy;
	} status_item_t;

	typedef struct packed {
		logic                        seen;
		logic                        fresh;
		logic                        cand;
		logic                        conf;
		logic [1:0]                  kind;
		logic [15:0]                 obs;
		logic [31:0]                 stable;
		logic [31:0]                 seq;
		logic [3:0]                  reason;
		logic [ecq_pkg::GEN_W-1:0]   mg;
		logic [ecq_pkg::GEN_W-1:0]   pg;
		logic [ecq_pkg::CODE_W-1:0]  code;
	} status_verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                          in_valid;
	logic                          in_stall;
	logic [ecq_pkg::MODE_W-1:0]    mode;
	logic [31:0]                   now_ms;
	logic [31:0]                   received_at_ms;
	logic [31:0]                   plan_seq;
	logic [ecq_pkg::GEN_W-1:0]     map_gen;
	logic [ecq_pkg::GEN_W-1:0]     planned_gen;
	logic [ecq_pkg::FCNT_W-1:0]    detected_count;
	logic [ecq_pkg::FCNT_W-1:0]    reachable_count;
	logic [ecq_pkg::CODE_W-1:0]    status_code;
	logic                          explore_on;
	logic                          goal_busy;
	logic                          handover_busy;

	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          status_seen;
	logic                          report_recent;
	logic                          candidate;
	logic                          confirmed;
	logic [1:0]                    depletion_kind;
	logic [15:0]                   observation_count;
	logic [31:0]                   stable_ms;
	logic [31:0]                   last_plan_seq;
	logic [3:0]                    reason_code;
	logic [ecq_pkg::GEN_W-1:0]     held_map_gen;
	logic [ecq_pkg::GEN_W-1:0]     held_planned_gen;
	logic [ecq_pkg::CODE_W-1:0]    held_status_code;

	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ecq_pkg::ADDR_W-1:0]    paddr;
	logic [ecq_pkg::DATA_W-1:0]    pwdata;
	logic [ecq_pkg::DATA_W-1:0]    prdata;
	logic                          pready;

	exhaustion_confirm_qualifier i_dut (.*);

	always #6 clk = ~clk;

	// Register copies
	logic [ecq_pkg::MINOBS_W-1:0] min_obs_cfg;
	logic [ecq_pkg::MSTAB_W-1:0]  min_stable_cfg;
	logic [ecq_pkg::TOUT_W-1:0]   timeout_cfg;
	logic [ecq_pkg::MASK_W-1:0]   allow_cfg;

	// Tracker state
	logic             trk_seen, trk_fresh, trk_cand, trk_conf;
	ecq_pkg::kind_t   trk_kind;
	logic [15:0]      trk_obs;
	logic [31:0]      trk_stable, trk_start, trk_last_rx, trk_cand_mg, trk_cand_pg, trk_seq;
	logic [31:0]      trk_echo_mg, trk_echo_pg;
	logic [1:0]       trk_echo_code;
	ecq_pkg::reason_t trk_reason;

	status_verdict_t pending_verdicts[$];
	int unsigned     fail_count = 0;
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_stall_pct = 0;
	int unsigned     hold_left = 0;
	int unsigned     quiet_cycles = 0;

	// Random walk that keeps reports well formed
	logic [31:0]    walk_time, walk_seq, walk_mg, walk_pg;
	ecq_pkg::kind_t walk_kind;

	task automatic log_failure(input string msg);
		if (fail_count < PRINT_LIMIT)
			$display("[%0t] MISMATCH %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			log_failure($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// ---------------------------------------------------------------- predictor

	task automatic clear_tracker(input ecq_pkg::reason_t why);
		trk_seen = 1'b0;
		trk_fresh = 1'b0;
		trk_cand = 1'b0;
		trk_conf = 1'b0;
		trk_kind = ecq_pkg::KIND_NONE;
		trk_obs = '0;
		trk_stable = '0;
		trk_start = '0;
		trk_last_rx = '0;
		trk_cand_mg = '0;
		trk_cand_pg = '0;
		trk_seq = '0;
		trk_echo_mg = '0;
		trk_echo_pg = '0;
		trk_echo_code = '0;
		trk_reason = why;
	endtask

	task automatic abandon_candidate(input ecq_pkg::reason_t why);
		trk_cand = 1'b0;
		trk_conf = 1'b0;
		trk_kind = ecq_pkg::KIND_NONE;
		trk_obs = '0;
		trk_stable = '0;
		trk_start = '0;
		trk_cand_mg = '0;
		trk_cand_pg = '0;
		trk_reason = why;
	endtask

	// A report from the future has age zero
	function automatic logic report_is_fresh(input logic [31:0] now_t);
		logic [31:0] age;
		age = (now_t >= trk_last_rx) ? now_t - trk_last_rx : 32'd0;
		return age <= timeout_cfg;
	endfunction

	task automatic recheck_freshness(input logic [31:0] now_t);
		trk_fresh = trk_seen && report_is_fresh(now_t);
		if (!trk_fresh && !trk_conf)
			abandon_candidate(ecq_pkg::RSN_STALE);
	endtask

	function automatic ecq_pkg::kind_t classify_report(input logic [1:0] code,
		input logic [15:0] det, input logic [15:0] reach);
		if (code == ecq_pkg::ST_NO_FRONTIERS && det == 0 && reach == 0)
			return ecq_pkg::KIND_NO_FRONTIERS;
		if (code == ecq_pkg::ST_NO_REACHABLE && det != 0 && reach == 0)
			return ecq_pkg::KIND_NO_REACHABLE;
		if (code == ecq_pkg::ST_NO_SELECTABLE && det != 0)
			return ecq_pkg::KIND_NO_SELECTABLE;
		return ecq_pkg::KIND_NONE;
	endfunction

	task automatic absorb_report(input status_item_t it);
		ecq_pkg::kind_t k;
		logic           elapsed_ok;
		trk_seen = 1'b1;
		trk_last_rx = it.received_at_ms;
		trk_fresh = report_is_fresh(it.now_ms);
		trk_echo_mg = it.map_gen;
		trk_echo_pg = it.planned_gen;
		trk_echo_code = it.status_code;

		// No plan: keep a confirmed candidate, drop anything else
		if (it.plan_seq == 0) begin
			if (!trk_conf)
				abandon_candidate(ecq_pkg::RSN_NO_PLAN);
			return;
		end
		if (it.plan_seq < trk_seq)
			abandon_candidate(ecq_pkg::RSN_RESTARTED);
		if (it.plan_seq == trk_seq) begin
			recheck_freshness(it.now_ms);
			return;
		end
		trk_seq = it.plan_seq;

		k = classify_report(it.status_code, it.detected_count, it.reachable_count);
		if (k == ecq_pkg::KIND_NONE || !allow_cfg[int'(k) - 1] || !it.explore_on ||
				it.goal_busy || it.handover_busy) begin
			abandon_candidate(k == ecq_pkg::KIND_NONE ? ecq_pkg::RSN_NOT_EXHAUSTED :
				ecq_pkg::RSN_INADMISSIBLE);
			return;
		end

		// Same candidate: count and age it; otherwise start afresh
		if (trk_cand && trk_kind == k && trk_cand_mg == it.map_gen &&
				trk_cand_pg == it.planned_gen) begin
			if (trk_obs != 16'hFFFF)
				trk_obs++;
			if (it.now_ms >= trk_start) begin
				trk_stable = it.now_ms - trk_start;
				elapsed_ok = trk_stable >= min_stable_cfg;
			end else begin
				trk_stable = '0;
				elapsed_ok = 1'b0;
			end
		end else begin
			trk_cand = 1'b1;
			trk_conf = 1'b0;
			trk_kind = k;
			trk_obs = 16'd1;
			trk_stable = '0;
			trk_start = it.now_ms;
			trk_cand_mg = it.map_gen;
			trk_cand_pg = it.planned_gen;
			elapsed_ok = (min_stable_cfg == 0);
		end

		trk_reason = ecq_pkg::RSN_OBSERVED;
		if (trk_obs >= min_obs_cfg && elapsed_ok) begin
			trk_conf = 1'b1;
			trk_reason = ecq_pkg::RSN_CONFIRMED;
		end
	endtask

	task automatic qualify_item(input status_item_t it, output status_verdict_t v);
		case (it.mode)
			ecq_pkg::MODE_CLEAR:  clear_tracker(ecq_pkg::RSN_CLEARED);
			ecq_pkg::MODE_REPORT: absorb_report(it);
			default:              recheck_freshness(it.now_ms);
		endcase
		v.seen = trk_seen;
		v.fresh = trk_fresh;
		v.cand = trk_cand;
		v.conf = trk_conf;
		v.kind = trk_kind;
		v.obs = trk_obs;
		v.stable = trk_stable;
		v.seq = trk_seq;
		v.reason = trk_reason;
		v.mg = trk_echo_mg;
		v.pg = trk_echo_pg;
		v.code = trk_echo_code;
	endtask

	// ---------------------------------------------------------------- item builders

	function automatic status_item_t make_tick(input logic [31:0] now_t);
		status_item_t it;
		it = '0;
		it.mode = ecq_pkg::MODE_TICK;
		it.now_ms = now_t;
		return it;
	endfunction

	function automatic status_item_t make_clear();
		status_item_t it;
		it = '0;
		it.mode = ecq_pkg::MODE_CLEAR;
		it.now_ms = $urandom;
		return it;
	endfunction

	// Report whose code and frontier counts fit the given kind
	function automatic status_item_t make_report(input logic [31:0] seq,
		input logic [31:0] now_t, input logic [31:0] rx, input logic [31:0] mg,
		input logic [31:0] pg, input ecq_pkg::kind_t k);
		status_item_t it;
		it.mode = ecq_pkg::MODE_REPORT;
		it.now_ms = now_t;
		it.received_at_ms = rx;
		it.plan_seq = seq;
		it.map_gen = mg;
		it.planned_gen = pg;
		it.explore_on = 1'b1;
		it.goal_busy = 1'b0;
		it.handover_busy = 1'b0;
		case (k)
			ecq_pkg::KIND_NO_FRONTIERS: begin
				it.status_code = ecq_pkg::ST_NO_FRONTIERS;
				it.detected_count = '0;
				it.reachable_count = '0;
			end
			ecq_pkg::KIND_NO_REACHABLE: begin
				it.status_code = ecq_pkg::ST_NO_REACHABLE;
				it.detected_count = 16'($urandom_range(1, 65535));
				it.reachable_count = '0;
			end
			ecq_pkg::KIND_NO_SELECTABLE: begin
				it.status_code = ecq_pkg::ST_NO_SELECTABLE;
				it.detected_count = 16'($urandom_range(1, 65535));
				it.reachable_count = 16'($urandom);
			end
			default: begin
				it.status_code = ecq_pkg::ST_OTHER;
				it.detected_count = 16'($urandom);
				it.reachable_count = 16'($urandom);
			end
		endcase
		return it;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic send_item(input status_item_t it);
		status_verdict_t v;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		mode <= it.mode;
		now_ms <= it.now_ms;
		received_at_ms <= it.received_at_ms;
		plan_seq <= it.plan_seq;
		map_gen <= it.map_gen;
		planned_gen <= it.planned_gen;
		detected_count <= it.detected_count;
		reachable_count <= it.reachable_count;
		status_code <= it.status_code;
		explore_on <= it.explore_on;
		goal_busy <= it.goal_busy;
		handover_busy <= it.handover_busy;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		qualify_item(it, v);
		pending_verdicts.push_back(v);
	endtask

	// Wait until every result is back and the pipeline is empty
	task automatic wait_for_verdicts();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [ecq_pkg::REGSEL_W-1:0] idx,
		input logic [31:0] value);
		wait_for_verdicts();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ecq_pkg::REG_MIN_OBS:    min_obs_cfg = value[ecq_pkg::MINOBS_W-1:0];
			ecq_pkg::REG_MIN_STABLE: min_stable_cfg = value[ecq_pkg::MSTAB_W-1:0];
			ecq_pkg::REG_TIMEOUT:    timeout_cfg = value[ecq_pkg::TOUT_W-1:0];
			default:                 allow_cfg = value[ecq_pkg::MASK_W-1:0];
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_cases();
		status_item_t it;
		send_item(make_tick(32'd1000));
		send_item(make_report(32'd0, 32'd1010, 32'd1005, 32'd7, 32'd7,
			ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_report(32'd5, 32'd1020, 32'd1015, 32'd7, 32'd7,
			ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_report(32'd6, 32'd1100, 32'd1090, 32'd7, 32'd7,
			ecq_pkg::KIND_NO_FRONTIERS));
		// repeated sequence number
		send_item(make_report(32'd6, 32'd1150, 32'd1140, 32'd7, 32'd7,
			ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_report(32'd7, 32'd1200, 32'd1195, 32'd7, 32'd7,
			ecq_pkg::KIND_NO_FRONTIERS));
		// no plan and staleness leave a confirmed candidate alone
		send_item(make_report(32'd0, 32'd1300, 32'd1290, 32'd8, 32'd7, ecq_pkg::KIND_NONE));
		send_item(make_tick(32'd5000));
		// lower sequence number restarts
		send_item(make_report(32'd3, 32'd5010, 32'd5000, 32'd9, 32'd8,
			ecq_pkg::KIND_NO_REACHABLE));
		// report from the future
		send_item(make_report(32'd4, 32'd5020, 32'd6000, 32'd9, 32'd8,
			ecq_pkg::KIND_NO_REACHABLE));
		// clock behind candidate start
		send_item(make_report(32'd5, 32'd4000, 32'd3990, 32'd9, 32'd8,
			ecq_pkg::KIND_NO_REACHABLE));
		it = make_report(32'd6, 32'd5030, 32'd5030, 32'd9, 32'd8, ecq_pkg::KIND_NO_REACHABLE);
		it.goal_busy = 1'b1;
		send_item(it);
		it = make_report(32'd7, 32'd5040, 32'd5040, 32'd9, 32'd8, ecq_pkg::KIND_NO_REACHABLE);
		it.handover_busy = 1'b1;
		send_item(it);
		it = make_report(32'd8, 32'd5050, 32'd5050, 32'd9, 32'd8, ecq_pkg::KIND_NO_REACHABLE);
		it.explore_on = 1'b0;
		send_item(it);
		send_item(make_report(32'd9, 32'd5060, 32'd5060, 32'd9, 32'd8, ecq_pkg::KIND_NONE));
		it = make_report(32'd10, 32'd5070, 32'd5070, 32'd9, 32'd8,
			ecq_pkg::KIND_NO_SELECTABLE);
		it.detected_count = '0;
		send_item(it);
		it = make_report(32'd11, 32'd5080, 32'd5080, 32'd9, 32'd8,
			ecq_pkg::KIND_NO_FRONTIERS);
		it.detected_count = 16'd5;
		send_item(it);
		it = make_report(32'd12, 32'd5090, 32'd5090, 32'd9, 32'd8,
			ecq_pkg::KIND_NO_SELECTABLE);
		it.detected_count = 16'd1;
		it.reachable_count = 16'hFFFF;
		send_item(it);
		// unused mode behaves as a tick
		it = make_tick(32'd5100);
		it.mode = MODE_SPARE;
		send_item(it);
		send_item(make_clear());
		// all fields at their maximum
		it = '1;
		it.mode = ecq_pkg::MODE_REPORT;
		send_item(it);
		it.goal_busy = 1'b0;
		it.handover_busy = 1'b0;
		it.plan_seq = 32'hFFFF_FFFE;
		send_item(it);
		send_item(make_tick(32'd0));
	endtask

	task automatic test_register_extremes();
		logic [31:0] t;
		t = 32'd20000;
		write_cfg(ecq_pkg::REG_ALLOW_MASK, 32'd0);
		send_item(make_clear());
		send_item(make_report(32'd1, t, t, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_report(32'd2, t + 5, t, '0, '0, ecq_pkg::KIND_NO_SELECTABLE));
		write_cfg(ecq_pkg::REG_ALLOW_MASK, 32'd1);
		send_item(make_report(32'd3, t + 10, t + 10, '0, '0, ecq_pkg::KIND_NO_REACHABLE));
		send_item(make_report(32'd4, t + 20, t + 20, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
		// zero observations needed: confirm on the first one
		write_cfg(ecq_pkg::REG_MIN_OBS, 32'd0);
		write_cfg(ecq_pkg::REG_ALLOW_MASK, 32'd7);
		send_item(make_report(32'd5, t + 30, t + 30, '0, '0, ecq_pkg::KIND_NO_SELECTABLE));
		write_cfg(ecq_pkg::REG_MIN_OBS, 32'd1);
		write_cfg(ecq_pkg::REG_MIN_STABLE, 32'hFFFF_FFFF);
		send_item(make_clear());
		send_item(make_report(32'd1, t + 40, t + 40, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_report(32'd2, t + 50, t + 50, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
		write_cfg(ecq_pkg::REG_TIMEOUT, 32'd0);
		send_item(make_tick(t + 50));
		send_item(make_tick(t + 51));
		write_cfg(ecq_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
		send_item(make_report(32'd3, t + 60, t + 60, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_tick(32'hFFFF_FFFF));
		write_cfg(ecq_pkg::REG_MIN_STABLE, 32'd100);
		write_cfg(ecq_pkg::REG_MIN_OBS, 32'd2);
		write_cfg(ecq_pkg::REG_TIMEOUT, 32'd1000);
		send_item(make_report(32'd4, t + 100, t + 100, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_report(32'd5, t + 150, t + 150, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
		send_item(make_report(32'd6, t + 200, t + 200, '0, '0, ecq_pkg::KIND_NO_FRONTIERS));
	endtask

	// Keep one candidate going under a threshold it cannot reach
	task automatic test_long_candidate();
		logic [31:0] t;
		write_cfg(ecq_pkg::REG_MIN_OBS, 32'hFFFF);
		write_cfg(ecq_pkg::REG_MIN_STABLE, 32'd0);
		write_cfg(ecq_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(make_clear());
		t = $urandom;
		for (int unsigned i = 1; i <= LONG_ITEMS; i++)
			send_item(make_report(i, t + i, t + i, 32'd9, 32'd9,
				ecq_pkg::KIND_NO_SELECTABLE));
	endtask

	// Hold the receiver off while items keep coming, then let it all drain
	task automatic test_back_pressure();
		write_cfg(ecq_pkg::REG_MIN_OBS, 32'd3);
		write_cfg(ecq_pkg::REG_TIMEOUT, 32'd1000);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		walk_time = $urandom_range(0, 1000000);
		walk_seq = '0;
		walk_mg = $urandom;
		walk_pg = walk_mg;
		walk_kind = ecq_pkg::KIND_NO_FRONTIERS;
		hold_left = 80;
		repeat (30) send_random_item();
		wait_for_verdicts();
		repeat (10) send_random_item();
	endtask

	task automatic send_random_item();
		status_item_t it;
		int unsigned  pick;
		pick = $urandom_range(99);
		if (pick < 64) begin
			// continue or start a candidate
			walk_time += $urandom_range(0, 400);
			if ($urandom_range(9) == 0) begin
				walk_mg = $urandom;
				walk_pg = $urandom_range(1) ? walk_mg : $urandom;
				walk_kind = ecq_pkg::kind_t'($urandom_range(1, 3));
			end
			walk_seq += $urandom_range(1, 3);
			it = make_report(walk_seq, walk_time, walk_time - $urandom_range(0, 300),
				walk_mg, walk_pg, walk_kind);
			if ($urandom_range(24) == 0)
				it.goal_busy = 1'b1;
			if ($urandom_range(24) == 0)
				it.handover_busy = 1'b1;
			if ($urandom_range(24) == 0)
				it.explore_on = 1'b0;
			if ($urandom_range(19) == 0)
				it.received_at_ms = walk_time + $urandom_range(1, 500);
		end else if (pick < 76) begin
			walk_time += ($urandom_range(7) == 0) ? $urandom_range(500, 5000) :
				$urandom_range(0, 300);
			it = make_tick(walk_time);
			if ($urandom_range(3) == 0)
				it.mode = MODE_SPARE;
		end else if (pick < 82) begin
			it = make_report(walk_seq, walk_time, walk_time, walk_mg, walk_pg, walk_kind);
		end else if (pick < 86) begin
			walk_seq = (walk_seq > 1) ? $urandom_range(1, walk_seq - 1) : 32'd1;
			it = make_report(walk_seq, walk_time, walk_time, walk_mg, walk_pg, walk_kind);
		end else if (pick < 89) begin
			it = make_report('0, walk_time, walk_time, walk_mg, walk_pg, walk_kind);
		end else if (pick < 91) begin
			it = make_clear();
		end else begin
			// noise across the whole field range
			it.mode = ecq_pkg::MODE_W'($urandom_range(0, 3));
			it.now_ms = $urandom;
			it.received_at_ms = $urandom;
			it.plan_seq = $urandom;
			it.map_gen = $urandom;
			it.planned_gen = $urandom;
			it.detected_count = 16'($urandom);
			it.reachable_count = 16'($urandom);
			it.status_code = ecq_pkg::CODE_W'($urandom_range(0, 3));
			it.explore_on = 1'($urandom_range(1));
			it.goal_busy = 1'($urandom_range(1));
			it.handover_busy = 1'($urandom_range(1));
		end
		send_item(it);
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct,
		input int unsigned stall_pct);
		write_cfg(ecq_pkg::REG_MIN_OBS, $urandom_range(1, 5));
		write_cfg(ecq_pkg::REG_MIN_STABLE, $urandom_range(1) ? 32'd0 : $urandom_range(1, 800));
		write_cfg(ecq_pkg::REG_TIMEOUT, $urandom_range(200, 2000));
		write_cfg(ecq_pkg::REG_ALLOW_MASK, $urandom_range(1, 7));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (PHASE_ITEMS) send_random_item();
	endtask

	// ---------------------------------------------------------------- receiver side

	// Stall the result channel: forced hold-off first, then random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Check each result against the oldest expectation
	always @(posedge clk) begin : result_check
		status_verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				log_failure("result with no transaction outstanding");
			end else begin
				want = pending_verdicts.pop_front();
				compare_field("status_seen", 32'(status_seen), 32'(want.seen));
				compare_field("report_recent", 32'(report_recent), 32'(want.fresh));
				compare_field("candidate", 32'(candidate), 32'(want.cand));
				compare_field("confirmed", 32'(confirmed), 32'(want.conf));
				compare_field("depletion_kind", 32'(depletion_kind), 32'(want.kind));
				compare_field("observation_count", 32'(observation_count),
					32'(want.obs));
				compare_field("stable_ms", stable_ms, want.stable);
				compare_field("last_plan_seq", last_plan_seq, want.seq);
				compare_field("reason_code", 32'(reason_code), 32'(want.reason));
				compare_field("held_map_gen", held_map_gen, want.mg);
				compare_field("held_planned_gen", held_planned_gen, want.pg);
				compare_field("held_status_code", 32'(held_status_code), 32'(want.code));
			end
		end
	end

	// Abort if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = ecq_pkg::MODE_TICK;
		now_ms = '0;
		received_at_ms = '0;
		plan_seq = '0;
		map_gen = '0;
		planned_gen = '0;
		detected_count = '0;
		reachable_count = '0;
		status_code = ecq_pkg::ST_OTHER;
		explore_on = 1'b0;
		goal_busy = 1'b0;
		handover_busy = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		min_obs_cfg = ecq_pkg::MIN_OBS_RST;
		min_stable_cfg = ecq_pkg::MIN_STABLE_RST;
		timeout_cfg = ecq_pkg::TIMEOUT_RST;
		allow_cfg = ecq_pkg::ALLOW_MASK_RST;
		clear_tracker(ecq_pkg::RSN_INIT);
		walk_time = '0;
		walk_seq = '0;
		walk_mg = '0;
		walk_pg = '0;
		walk_kind = ecq_pkg::KIND_NO_FRONTIERS;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_register_extremes();
		test_long_candidate();
		test_back_pressure();
		test_random_traffic(0, 0);
		test_random_traffic(72, 0);
		test_random_traffic(0, 72);
		test_random_traffic(17, 17);
		wait_for_verdicts();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
sv/ecq_pkg.sv
sv/exhaustion_confirm_qualifier.sv
test/tb_exhaustion_confirm_qualifier.sv
